// File: design/ritoa_pkg.sv
// Shared constants, types and helpers for the radix integer-to-ASCII converter.
// No dependencies; imported by ritoa_divider and radix_integer_to_ascii.
package ritoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned BITS_PER_CYCLE = 4;
  localparam int unsigned DIV_CYCLES = VALUE_WIDTH / BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W = ADDR_W + 1;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned FLAGS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_FLAGS = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam int unsigned FLAG_UNSIGNED = 0;
  localparam int unsigned FLAG_LOWER = 1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [3:0]             remainder;
  } div_result_t;

  // Map one digit to its ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic lower);
    logic [7:0] d8;
    d8 = {4'd0, digit};
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + d8;
    end else if (lower) begin
      digit_char = CHAR_LOWER_A + d8 - 8'd10;
    end else begin
      digit_char = CHAR_UPPER_A + d8 - 8'd10;
    end
  endfunction

endpackage

// File: design/radix_integer_to_ascii.sv
// Radix integer-to-ASCII converter: one word in, its digits in base 2..16 out, MSD first.
// Each digit passes through the shared divider: a load, then DIV_CYCLES steps.
// Emission: a minus sign for a negative word, then per character a digit store read and a load.
// After the last character the sequencer goes idle before the next accept;
// one word at a time, s_axis_tready low meanwhile.
// Reset (rst_ni low, async): radix 10, flags 0, sequencer idle, output empty.
// Depends on ritoa_pkg and ritoa_divider.
module radix_integer_to_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ritoa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ritoa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input words
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ritoa_pkg::VALUE_WIDTH-1:0]   s_axis_tdata_i,  // [31:0] value
  // output characters
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,  // [7:0] character
  output logic                                m_axis_tlast_o   // last
);
  import ritoa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [FLAGS_W-1:0] flags_q, flags_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               neg_q, neg_d;
  logic               lower_q, lower_d;

  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  logic [3:0]         digit_store [VALUE_WIDTH];
  logic [3:0]         rd_data_q;

  logic                   accept;
  logic                   out_free;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_W-1:0]     base;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  div_result_t            div_res;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // saturate the base into 2..16
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  assign in_neg = !flags_q[FLAG_UNSIGNED] && s_axis_tdata_i[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;

  always_comb begin
    radix_d = radix_q;
    flags_d = flags_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RADIX:        radix_d = cfg_data_i[RADIX_W-1:0];
        REG_FORMAT_FLAGS: flags_d = cfg_data_i[FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    neg_d        = neg_q;
    lower_d      = lower_q;
    div_start    = 1'b0;
    div_dividend = in_mag;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_d     = in_neg;
          lower_d   = flags_q[FLAG_LOWER];
          cnt_d     = '0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          cnt_d = cnt_q + 1'b1;
          if ((div_res.quotient == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1))) begin
            idx_d   = cnt_q[ADDR_W-1:0];
            state_d = neg_q ? ST_SIGN : ST_READ;
          end else begin
            // next digit: divide the quotient again
            div_start    = 1'b1;
            div_dividend = div_res.quotient;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(rd_data_q, lower_q);
          out_last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ritoa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (base),
    .result_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radix_q     <= RADIX_RESET;
      flags_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      lower_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      radix_q     <= radix_d;
      flags_q     <= flags_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      lower_q     <= lower_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // digit store, least significant digit at address 0
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV) && div_res.done) begin
      digit_store[cnt_q[ADDR_W-1:0]] <= div_res.remainder;
    end
    rd_data_q <= digit_store[idx_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: design/ritoa_divider.sv
// Iterative divider by a small radix (2..16), BITS_PER_CYCLE quotient bits per cycle.
// Depends on ritoa_pkg.
module ritoa_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ritoa_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [ritoa_pkg::RADIX_W-1:0]    divisor_i,
  output ritoa_pkg::div_result_t           result_o
);
  import ritoa_pkg::*;

  logic                   busy_q, busy_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] shift_q, shift_d;
  logic [3:0]             rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q, div_d;
  logic                   done_q, done_d;

  logic [VALUE_WIDTH-1:0] sh;
  logic [3:0]             rm;
  logic [4:0]             trial;

  always_comb begin
    sh = shift_q;
    rm = rem_q;
    trial = '0;
    // shift in the top dividend bit, compare-subtract, shift the quotient bit in at the bottom
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {rm, sh[VALUE_WIDTH-1]};
      if (trial >= div_q) begin
        trial = trial - div_q;
        sh = {sh[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        sh = {sh[VALUE_WIDTH-2:0], 1'b0};
      end
      rm = trial[3:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    done_d  = 1'b0;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (busy_q) begin
      shift_d = sh;
      rem_d   = rm;
      cnt_d   = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign result_o.done      = done_q;
  assign result_o.quotient  = shift_q;
  assign result_o.remainder = rem_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_integer_to_ascii: streams words in, predicts each
// character transfer and checks data and tlast in order. Needs ritoa_pkg and the
// radix_integer_to_ascii RTL.
module tb_top;
  import ritoa_pkg::*;

  // indexes past the register list; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int LONG_HOLD_CYCLES = 500;
  localparam int TAIL_CYCLES = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 45;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [VALUE_WIDTH-1:0] s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [7:0]             m_axis_tdata_o;
  logic                   m_axis_tlast_o;

  // register copies used for prediction
  logic [RADIX_W-1:0]     cfg_radix = RADIX_RESET;
  logic [FLAGS_W-1:0]     cfg_flags = '0;

  logic [VALUE_WIDTH-1:0] word_q[$];
  ascii_char_t            ascii_q[$];
  ascii_char_t            exp_char;
  int                     words_queued = 0;
  int                     words_accepted = 0;
  int                     chars_checked = 0;
  int                     reg_writes = 0;
  int                     err_cnt = 0;
  int                     tx_gap = 0;
  int                     rx_hold = 0;
  bit                     quiet_mode = 1'b0;
  bit                     rx_long_hold_arm = 1'b0;
  bit                     rx_long_hold_done = 1'b0;

  radix_integer_to_ascii u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5ns clk_i = ~clk_i;

  // Expand one word into its characters, sign first, most significant digit next.
  function automatic void convert_word(input logic [VALUE_WIDTH-1:0] word);
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             digits[VALUE_WIDTH];
    int unsigned            base;
    int                     n;
    string                  digit_set;
    base = 32'((cfg_radix < RADIX_MIN) ? RADIX_MIN :
               (cfg_radix > RADIX_MAX) ? RADIX_MAX : cfg_radix);
    digit_set = cfg_flags[FLAG_LOWER] ? "0123456789abcdef" : "0123456789ABCDEF";
    mag = word;
    if (!cfg_flags[FLAG_UNSIGNED] && word[VALUE_WIDTH-1]) begin
      mag = ~word + 1'b1;
      ascii_q.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    n = 0;
    do begin
      digits[n] = 4'(mag % base);
      mag = mag / base;
      n++;
    end while (mag != 0 && n < VALUE_WIDTH);
    for (int k = n - 1; k >= 0; k--) begin
      ascii_q.push_back('{code: 8'(digit_set[digits[k]]), last: (k == 0)});
    end
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 255);
      1: return 32'd0 - $urandom_range(1, 1000);
      2: return 32'd1 << $urandom_range(0, 31);
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // input side: predict on each accepted transfer, then offer the next word
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      convert_word(s_axis_tdata_i);
      words_accepted++;
    end
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        s_axis_tdata_i  <= word_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        tx_gap = pick_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // output side: check each transfer, then pick the ready for the next cycle
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      chars_checked++;
      if (ascii_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        exp_char = ascii_q.pop_front();
        if (m_axis_tdata_o !== exp_char.code) begin
          err_cnt++;
          $display("%0t: character mismatch, expected %h actual %h",
                   $time, exp_char.code, m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== exp_char.last) begin
          err_cnt++;
          $display("%0t: tlast mismatch, expected %b actual %b",
                   $time, exp_char.last, m_axis_tlast_o);
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (rx_long_hold_arm && !rx_long_hold_done) begin
      // hold off long enough for the block to back up into its input
      rx_long_hold_done = 1'b1;
      rx_hold = LONG_HOLD_CYCLES - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      rx_hold = pick_gap();
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_RADIX:        cfg_radix = data;
      REG_FORMAT_FLAGS: cfg_flags = data[FLAGS_W-1:0];
      default: ;
    endcase
  endtask

  // Count the words just loaded and wait until every one is converted and checked.
  task automatic run_batch();
    words_queued += word_q.size();
    do @(posedge clk_i);
    while (words_accepted != words_queued || ascii_q.size() != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // reset settings: decimal, signed
    word_q = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h075B_CD15};
    run_batch();
    write_reg(REG_SPARE_LO, 5'd3);
    write_reg(REG_SPARE_HI, 5'd31);
    word_q = '{32'hFFFF_FF85};
    run_batch();
    // upper data bits of the flags write drop out: lowercase, unsigned
    write_reg(REG_RADIX, RADIX_MAX);
    write_reg(REG_FORMAT_FLAGS, 5'b11111);
    word_q = '{32'hDEAD_BEEF, 32'hFFFF_FFFF};
    run_batch();
    write_reg(REG_FORMAT_FLAGS, 5'd0);
    word_q = '{32'hDEAD_BEEF, 32'h0000_ABCD};
    run_batch();
    write_reg(REG_RADIX, RADIX_MIN);
    write_reg(REG_FORMAT_FLAGS, 5'(1 << FLAG_UNSIGNED));
    word_q = '{32'hFFFF_FFFF, 32'h0000_0005};
    run_batch();
    // most negative word in binary gives the longest run of characters
    write_reg(REG_FORMAT_FLAGS, 5'd0);
    word_q = '{32'h8000_0000, 32'hFFFF_FFFE};
    run_batch();
    // out-of-range radix saturates at both ends
    write_reg(REG_RADIX, 5'd0);
    word_q = '{32'h0000_000A};
    run_batch();
    write_reg(REG_RADIX, 5'd1);
    word_q = '{32'h0000_0006};
    run_batch();
    write_reg(REG_RADIX, 5'd31);
    write_reg(REG_FORMAT_FLAGS, 5'(1 << FLAG_LOWER));
    word_q = '{32'hFFFF_FF00, 32'h00FA_CE00};
    run_batch();
    write_reg(REG_RADIX, 5'd17);
    write_reg(REG_FORMAT_FLAGS, 5'(1 << FLAG_UNSIGNED));
    word_q = '{32'hCAFE_BABE};
    run_batch();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet_mode = (p == 5);
      rx_long_hold_arm = (p == 2);
      if ($urandom_range(0, 4) == 0) write_reg(REG_RADIX, 5'($urandom));
      else write_reg(REG_RADIX, 5'($urandom_range(RADIX_MIN, RADIX_MAX)));
      write_reg(REG_FORMAT_FLAGS, 5'($urandom));
      if (p == 4) write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 5'($urandom));
      for (int i = 0; i < WORDS_PER_PHASE; i++) word_q.push_back(random_word());
      run_batch();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("summary: %0d words, %0d characters checked, %0d register writes",
             words_accepted, chars_checked, reg_writes);
    $display("summary: bases 2 to 16 with saturation, signed/unsigned, both letter cases");
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("timeout: %0d of %0d words accepted, %0d characters pending",
             words_accepted, words_queued, ascii_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
